// ===== design/tpu_pkg.sv =====
// tpu_pkg: shared types and constants for the tracker pattern unpacker
// no dependencies; imported by tpu_decoder, tpu_out_buf and the top level
`timescale 1ns / 1ps
`default_nettype none

package tpu_pkg;

  // field bits of a compressed lead byte
  localparam int unsigned FLD_NOTE  = 0;
  localparam int unsigned FLD_INSTR = 1;
  localparam int unsigned FLD_VOL   = 2;
  localparam int unsigned FLD_FXTYP = 3;
  localparam int unsigned FLD_FXPAR = 4;
  localparam int unsigned LEAD_FLAG = 7;

  localparam logic [4:0] MASK_NO_NOTE    = 5'h1E;
  localparam logic [6:0] NOTE_EMPTY      = 7'd0;
  localparam logic [6:0] NOTE_RAW_LIMIT  = 7'd97;
  localparam logic [6:0] NOTE_RELEASE    = 7'd120;
  localparam logic [7:0] INSTR_NONE      = 8'hFF;
  localparam logic [6:0] VOL_LOW         = 7'h10;
  localparam logic [6:0] VOL_HIGH        = 7'h50;
  localparam logic [7:0] VOL_ABSENT      = 8'h80;
  localparam logic [5:0] CHANNELS_RESET  = 6'd2;

  typedef struct packed {
    logic [6:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [4:0] track;
    logic [7:0] line;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } event_push_t;

endpackage

`default_nettype wire

// ===== design/tpu_decoder.sv =====
// tpu_decoder: field collection state, track/line counters and event mapping
// depends on tpu_pkg; one byte is consumed per accepted transaction
`timescale 1ns / 1ps
`default_nettype none

module tpu_decoder
  import tpu_pkg::*;
#(
  parameter int MAX_LINES  = 256,
  parameter int MAX_TRACKS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output event_push_t      push
);

  localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam logic [6:0]    MAX_T7   = 7'(MAX_TRACKS);
  localparam logic [LW-1:0] LINE_MAX = LW'(MAX_LINES - 1);

  logic [5:0]    chan_r;
  logic [4:0]    mask_r, mask_nxt;
  logic [6:0]    note_r, note_nxt;
  logic [7:0]    instr_r, instr_nxt;
  logic [6:0]    vol_r, vol_nxt;
  logic [TW-1:0] track_r, track_nxt;
  logic [LW-1:0] line_r, line_nxt;
  event_push_t   push_r, push_nxt;

  logic [6:0]    chans;
  logic [6:0]    track_inc;
  logic [6:0]    v7;
  logic [4:0]    mask_step;
  logic [TW+7:0] track_ext;
  logic [LW+7:0] line_ext;

  always_comb begin
    // clamp the track count to 1..MAX_TRACKS
    if (chan_r == 6'd0) begin
      chans = 7'd1;
    end else if ({1'b0, chan_r} > MAX_T7) begin
      chans = MAX_T7;
    end else begin
      chans = {1'b0, chan_r};
    end
  end

  assign v7        = data_byte[6:0];
  assign track_inc = 7'(track_r) + 7'd1;
  assign track_ext = {8'b0, track_r};
  assign line_ext  = {8'b0, line_r};

  always_comb begin
    note_nxt  = note_r;
    instr_nxt = instr_r;
    vol_nxt   = vol_r;
    mask_step = mask_r;
    track_nxt = track_r;
    line_nxt  = line_r;
    push_nxt  = '{valid: 1'b0, ev: push_r.ev};

    if (accept) begin
      if (mask_r == 5'd0) begin
        // lead byte
        note_nxt  = NOTE_EMPTY;
        instr_nxt = INSTR_NONE;
        vol_nxt   = 7'd0;
        if (data_byte[LEAD_FLAG]) begin
          mask_step = data_byte[4:0];
        end else begin
          note_nxt  = v7;
          mask_step = MASK_NO_NOTE;
        end
      end else if (mask_r[FLD_NOTE]) begin
        note_nxt  = v7;
        mask_step[FLD_NOTE] = 1'b0;
      end else if (mask_r[FLD_INSTR]) begin
        instr_nxt = {1'b0, v7};
        mask_step[FLD_INSTR] = 1'b0;
      end else if (mask_r[FLD_VOL]) begin
        vol_nxt   = v7;
        mask_step[FLD_VOL] = 1'b0;
      end else if (mask_r[FLD_FXTYP]) begin
        mask_step[FLD_FXTYP] = 1'b0;
      end else begin
        mask_step[FLD_FXPAR] = 1'b0;
      end

      if (mask_step == 5'd0) begin
        // event complete
        if (note_nxt != NOTE_EMPTY) begin
          push_nxt.valid         = 1'b1;
          push_nxt.ev.note       = (note_nxt >= NOTE_RAW_LIMIT) ? NOTE_RELEASE
                                                                : note_nxt - 7'd1;
          push_nxt.ev.instrument = instr_nxt;
          push_nxt.ev.volume     = (vol_nxt >= VOL_LOW && vol_nxt <= VOL_HIGH)
                                   ? {1'b0, vol_nxt} : VOL_ABSENT;
          push_nxt.ev.track      = track_ext[4:0];
          push_nxt.ev.line       = line_ext[7:0];
        end
        if (track_inc >= chans) begin
          track_nxt = '0;
          if (line_r < LINE_MAX) begin
            line_nxt = line_r + LW'(1);
          end
        end else begin
          track_nxt = track_inc[TW-1:0];
        end
        note_nxt  = NOTE_EMPTY;
        instr_nxt = INSTR_NONE;
        vol_nxt   = 7'd0;
      end

      if (last_byte) begin
        mask_step = 5'd0;
        note_nxt  = NOTE_EMPTY;
        instr_nxt = INSTR_NONE;
        vol_nxt   = 7'd0;
        track_nxt = '0;
        line_nxt  = '0;
      end
    end
    mask_nxt = mask_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r       <= CHANNELS_RESET;
      mask_r       <= 5'd0;
      note_r       <= NOTE_EMPTY;
      instr_r      <= INSTR_NONE;
      vol_r        <= 7'd0;
      track_r      <= '0;
      line_r       <= '0;
      push_r.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        chan_r <= cfg_wdata;
      end
      mask_r       <= mask_nxt;
      note_r       <= note_nxt;
      instr_r      <= instr_nxt;
      vol_r        <= vol_nxt;
      track_r      <= track_nxt;
      line_r       <= line_nxt;
      push_r.valid <= push_nxt.valid;
    end
    push_r.ev <= push_nxt.ev;
  end

  assign push = push_r;

endmodule

`default_nettype wire

// ===== design/tpu_out_buf.sv =====
// tpu_out_buf: two-entry result buffer (output register plus skid register)
// depends on tpu_pkg; full flag is built from registers only, so stall does not feed back
`timescale 1ns / 1ps
`default_nettype none

module tpu_out_buf
  import tpu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire event_push_t push,
  output logic             full,
  output logic             out_valid,
  output event_t           out_ev,
  input  wire logic        out_stall
);

  logic   main_v_r, main_v_nxt;
  logic   skid_v_r, skid_v_nxt;
  event_t main_r, main_nxt;
  event_t skid_r, skid_nxt;
  logic   pop;

  assign pop = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = push.valid;
        skid_nxt   = push.ev;
      end else begin
        main_v_nxt = push.valid;
        main_nxt   = push.ev;
      end
    end else if (push.valid) begin
      if (!main_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = push.ev;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push.ev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // one slot must stay free for the event of a transaction in the decoder
  assign full      = skid_v_r || (main_v_r && push.valid);
  assign out_valid = main_v_r;
  assign out_ev    = main_r;

endmodule

`default_nettype wire

// ===== design/tracker_pattern_unpacker_unit.sv =====
// tracker_pattern_unpacker_unit: top level of the packed pattern byte unpacker
// depends on tpu_pkg, tpu_decoder and tpu_out_buf
//
//   channel   direction   ports
//   in_       sink        in_valid, in_stall, in_data_byte, in_last_byte
//   out_      source      out_valid, out_stall, out_note .. out_line
//   cfg_      sink        cfg_we, cfg_wdata (channel_count)
//
// one byte per cycle while in_stall is low; the decoder state update is the only loop
// an accepted closing byte's event is registered in the decoder, then in the result buffer, before out_
// the result buffer holds two events; in_stall rises while a byte waits and the buffer signals full
// synchronous reset returns the counters to zero and channel_count to 2
`timescale 1ns / 1ps
`default_nettype none

module tracker_pattern_unpacker_unit
  import tpu_pkg::*;
#(
  parameter int MAX_LINES  = 256,
  parameter int MAX_TRACKS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_note,
  output logic [7:0]      out_instrument,
  output logic [7:0]      out_volume,
  output logic [4:0]      out_track,
  output logic [7:0]      out_line
);

  logic        in_valid_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic        buf_full;
  logic        dec_accept;
  event_push_t push;
  event_t      out_ev;

  // input register; the decoder consumes it whenever the buffer does not signal full
  assign in_stall   = in_valid_r && buf_full;
  assign dec_accept = in_valid_r && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  tpu_decoder #(
    .MAX_LINES  (MAX_LINES),
    .MAX_TRACKS (MAX_TRACKS)
  ) u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (dec_accept),
    .data_byte (data_r),
    .last_byte (last_r),
    .push      (push)
  );

  tpu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ev    (out_ev),
    .out_stall (out_stall)
  );

  assign out_note       = out_ev.note;
  assign out_instrument = out_ev.instrument;
  assign out_volume     = out_ev.volume;
  assign out_track      = out_ev.track;
  assign out_line       = out_ev.line;

endmodule

`default_nettype wire
